FILE: design/sawarq_pkg.sv
`timescale 1ns / 1ps

package sawarq_pkg;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_RX      = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    localparam logic OUT_FRAME  = 1'b0;
    localparam logic OUT_STATUS = 1'b1;

    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_ACK    = 2'd1;
    localparam logic [1:0] ST_RETRY  = 2'd2;
    localparam logic [1:0] ST_FAILED = 2'd3;

    localparam logic [1:0] REG_OWN_ID   = 2'd0;
    localparam logic [1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_MAX_ATT  = 2'd2;
    localparam logic [1:0] REG_ACK_TYPE = 2'd3;

    localparam logic [7:0]  OWN_ID_RST   = 8'd1;
    localparam logic [15:0] TIMEOUT_RST  = 16'd3000;
    localparam logic [3:0]  MAX_ATT_RST  = 4'd3;
    localparam logic [7:0]  ACK_TYPE_RST = 8'h02;
    localparam logic [7:0]  ACK_MIN_LEN  = 8'd4;
    localparam logic [3:0]  ATT_SAT      = 4'd15;
    localparam logic [7:0]  RX_CNT_SAT   = 8'd255;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic       last_byte;
        logic [7:0] dest_id;
        logic [7:0] msg_type;
    } t_in_item;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] frame_byte;
        logic       run_last;
        logic [1:0] status;
    } t_out_item;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SEND,
        ACT_RETRY,
        ACT_FAIL,
        ACT_ACK
    } t_act;

    typedef enum logic [2:0] {
        PUT_NONE,
        PUT_HDR0,
        PUT_HDR1,
        PUT_HDR2,
        PUT_PAY,
        PUT_SUM,
        PUT_STAT
    } t_put;

    typedef struct packed {
        logic       apply;
        logic       rd_en;
        t_put       put;
        logic [1:0] stat_code;
        logic       stat_last;
    } t_dp_cmd;

    typedef struct packed {
        t_act act;
        logic out_free;
        logic pay_empty;
        logic pay_more;
    } t_dp_stat;

endpackage

FILE: design/sawarq_datapath.sv
`timescale 1ns / 1ps

module sawarq_datapath #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  sawarq_pkg::t_in_item  i_in_data,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data,
    input  logic                  i_out_stall,
    input  sawarq_pkg::t_dp_cmd   i_cmd,
    output sawarq_pkg::t_dp_stat  o_stat,
    output logic                  o_out_valid,
    output sawarq_pkg::t_out_item o_out_data
);

    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]  r_own_id;
    logic [15:0] r_timeout;
    logic [3:0]  r_max_att;
    logic [7:0]  r_ack_type;

    logic [7:0]  r_mem [MAX_PAYLOAD];
    logic [7:0]  r_rd;

    sawarq_pkg::t_in_item  r_in;
    logic [CW-1:0] r_pcount, n_pcount;
    logic [7:0]    r_dest, n_dest;
    logic [7:0]    r_type, n_type;
    logic          r_wait, n_wait;
    logic [3:0]    r_att, n_att;
    logic [15:0]   r_tick, n_tick;
    logic [7:0]    r_rxcnt, n_rxcnt;
    logic [7:0]    r_rxsum, n_rxsum;
    logic          r_rxok, n_rxok;
    logic          store_en;
    sawarq_pkg::t_act act;

    logic [7:0]    r_sum;
    logic [CW-1:0] r_idx;

    logic                  r_out_valid;
    sawarq_pkg::t_out_item r_out_data, n_out_data;
    logic                  out_free;

    logic [15:0] tick_inc;
    logic [3:0]  att_inc;
    logic [7:0]  rxcnt_inc;
    logic        ok_upd;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign tick_inc  = r_tick + 16'd1;
    assign att_inc   = (r_att != sawarq_pkg::ATT_SAT) ? r_att + 4'd1 : r_att;
    assign rxcnt_inc = (r_rxcnt != sawarq_pkg::RX_CNT_SAT) ? r_rxcnt + 8'd1 : r_rxcnt;

    always_comb begin
        ok_upd = r_rxok;
        if (r_rxcnt == 8'd0 && r_in.byte_value != r_dest) ok_upd = 1'b0;
        if (r_rxcnt == 8'd1 && r_in.byte_value != r_own_id) ok_upd = 1'b0;
        if (r_rxcnt == 8'd2 && r_in.byte_value != r_ack_type) ok_upd = 1'b0;
    end

    always_comb begin
        n_pcount = r_pcount;
        n_dest   = r_dest;
        n_type   = r_type;
        n_wait   = r_wait;
        n_att    = r_att;
        n_tick   = r_tick;
        n_rxcnt  = r_rxcnt;
        n_rxsum  = r_rxsum;
        n_rxok   = r_rxok;
        store_en = 1'b0;
        act      = sawarq_pkg::ACT_NONE;
        if (!r_wait) begin
            if (r_in.kind == sawarq_pkg::KIND_PAYLOAD) begin
                if (r_pcount < CW'(MAX_PAYLOAD)) begin
                    store_en = 1'b1;
                    n_pcount = r_pcount + CW'(1);
                end
                if (r_in.last_byte) begin
                    n_dest  = r_in.dest_id;
                    n_type  = r_in.msg_type;
                    n_wait  = 1'b1;
                    n_att   = 4'd0;
                    n_tick  = 16'd0;
                    n_rxcnt = 8'd0;
                    n_rxsum = 8'd0;
                    n_rxok  = 1'b1;
                    act     = sawarq_pkg::ACT_SEND;
                end
            end
        end else if (r_in.kind == sawarq_pkg::KIND_TICK) begin
            n_tick = tick_inc;
            if (tick_inc >= r_timeout) begin
                n_tick  = 16'd0;
                n_rxcnt = 8'd0;
                n_rxsum = 8'd0;
                n_rxok  = 1'b1;
                n_att   = att_inc;
                if (att_inc >= r_max_att) begin
                    n_wait   = 1'b0;
                    n_pcount = '0;
                    n_att    = 4'd0;
                    act      = sawarq_pkg::ACT_FAIL;
                end else begin
                    act = sawarq_pkg::ACT_RETRY;
                end
            end
        end else if (r_in.kind == sawarq_pkg::KIND_RX) begin
            n_rxok  = ok_upd;
            n_rxcnt = rxcnt_inc;
            if (!r_in.last_byte) begin
                n_rxsum = r_rxsum + r_in.byte_value;
            end else begin
                n_rxcnt = 8'd0;
                n_rxsum = 8'd0;
                n_rxok  = 1'b1;
                if (rxcnt_inc >= sawarq_pkg::ACK_MIN_LEN && ok_upd
                    && r_in.byte_value == r_rxsum) begin
                    n_wait   = 1'b0;
                    n_pcount = '0;
                    n_att    = 4'd0;
                    n_tick   = 16'd0;
                    act      = sawarq_pkg::ACT_ACK;
                end
            end
        end
    end

    always_comb begin
        n_out_data            = r_out_data;
        n_out_data.out_kind   = sawarq_pkg::OUT_FRAME;
        n_out_data.run_last   = 1'b0;
        n_out_data.status     = sawarq_pkg::ST_NONE;
        case (i_cmd.put)
            sawarq_pkg::PUT_HDR0: n_out_data.frame_byte = r_own_id;
            sawarq_pkg::PUT_HDR1: n_out_data.frame_byte = r_dest;
            sawarq_pkg::PUT_HDR2: n_out_data.frame_byte = r_type;
            sawarq_pkg::PUT_PAY:  n_out_data.frame_byte = r_rd;
            sawarq_pkg::PUT_SUM: begin
                n_out_data.frame_byte = r_sum;
                n_out_data.run_last   = 1'b1;
            end
            sawarq_pkg::PUT_STAT: begin
                n_out_data.out_kind   = sawarq_pkg::OUT_STATUS;
                n_out_data.frame_byte = 8'd0;
                n_out_data.run_last   = i_cmd.stat_last;
                n_out_data.status     = i_cmd.stat_code;
            end
            default: n_out_data.frame_byte = r_out_data.frame_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id    <= sawarq_pkg::OWN_ID_RST;
            r_timeout   <= sawarq_pkg::TIMEOUT_RST;
            r_max_att   <= sawarq_pkg::MAX_ATT_RST;
            r_ack_type  <= sawarq_pkg::ACK_TYPE_RST;
            r_pcount    <= '0;
            r_dest      <= 8'd0;
            r_type      <= 8'd0;
            r_wait      <= 1'b0;
            r_att       <= 4'd0;
            r_tick      <= 16'd0;
            r_rxcnt     <= 8'd0;
            r_rxsum     <= 8'd0;
            r_rxok      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sawarq_pkg::REG_OWN_ID:   r_own_id   <= i_cfg_data[7:0];
                    sawarq_pkg::REG_TIMEOUT:  r_timeout  <= i_cfg_data;
                    sawarq_pkg::REG_MAX_ATT:  r_max_att  <= i_cfg_data[3:0];
                    sawarq_pkg::REG_ACK_TYPE: r_ack_type <= i_cfg_data[7:0];
                    default: r_own_id <= r_own_id;
                endcase
            end
            if (i_cmd.apply) begin
                r_pcount <= n_pcount;
                r_dest   <= n_dest;
                r_type   <= n_type;
                r_wait   <= n_wait;
                r_att    <= n_att;
                r_tick   <= n_tick;
                r_rxcnt  <= n_rxcnt;
                r_rxsum  <= n_rxsum;
                r_rxok   <= n_rxok;
            end
            if (i_cmd.put != sawarq_pkg::PUT_NONE) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_in <= i_in_data;
        end
        if (i_cmd.put != sawarq_pkg::PUT_NONE) begin
            r_out_data <= n_out_data;
        end
        case (i_cmd.put)
            sawarq_pkg::PUT_HDR0: begin
                r_sum <= r_own_id;
                r_idx <= '0;
            end
            sawarq_pkg::PUT_HDR1: r_sum <= r_sum + r_dest;
            sawarq_pkg::PUT_HDR2: r_sum <= r_sum + r_type;
            sawarq_pkg::PUT_PAY: begin
                r_sum <= r_sum + r_rd;
                r_idx <= r_idx + CW'(1);
            end
            default: r_sum <= r_sum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply && store_en) begin
            r_mem[r_pcount[AW-1:0]] <= r_in.byte_value;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[r_idx[AW-1:0]];
        end
    end

    assign o_stat.act       = act;
    assign o_stat.out_free  = out_free;
    assign o_stat.pay_empty = (r_pcount == '0);
    assign o_stat.pay_more  = ((r_idx + CW'(1)) < r_pcount);
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out_data;

endmodule

FILE: design/sawarq_ctrl.sv
`timescale 1ns / 1ps

module sawarq_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  sawarq_pkg::t_dp_stat i_stat,
    output sawarq_pkg::t_dp_cmd  o_cmd,
    output logic                 o_idle
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_STAT,
        S_HDR0,
        S_HDR1,
        S_HDR2,
        S_PRD,
        S_PWR,
        S_SUM
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_stat_code, n_stat_code;
    logic       r_stat_last, n_stat_last;

    always_comb begin
        n_state          = r_state;
        n_stat_code      = r_stat_code;
        n_stat_last      = r_stat_last;
        o_cmd.apply      = 1'b0;
        o_cmd.rd_en      = 1'b0;
        o_cmd.put        = sawarq_pkg::PUT_NONE;
        o_cmd.stat_code  = r_stat_code;
        o_cmd.stat_last  = r_stat_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.apply = 1'b1;
                unique case (i_stat.act)
                    sawarq_pkg::ACT_SEND: n_state = S_HDR0;
                    sawarq_pkg::ACT_RETRY: begin
                        n_state     = S_STAT;
                        n_stat_code = sawarq_pkg::ST_RETRY;
                        n_stat_last = 1'b0;
                    end
                    sawarq_pkg::ACT_FAIL: begin
                        n_state     = S_STAT;
                        n_stat_code = sawarq_pkg::ST_FAILED;
                        n_stat_last = 1'b1;
                    end
                    sawarq_pkg::ACT_ACK: begin
                        n_state     = S_STAT;
                        n_stat_code = sawarq_pkg::ST_ACK;
                        n_stat_last = 1'b1;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_STAT: begin
                if (i_stat.out_free) begin
                    o_cmd.put = sawarq_pkg::PUT_STAT;
                    n_state   = r_stat_last ? S_IDLE : S_HDR0;
                end
            end
            S_HDR0: begin
                if (i_stat.out_free) begin
                    o_cmd.put = sawarq_pkg::PUT_HDR0;
                    n_state   = S_HDR1;
                end
            end
            S_HDR1: begin
                if (i_stat.out_free) begin
                    o_cmd.put = sawarq_pkg::PUT_HDR1;
                    n_state   = S_HDR2;
                end
            end
            S_HDR2: begin
                if (i_stat.out_free) begin
                    o_cmd.put = sawarq_pkg::PUT_HDR2;
                    n_state   = i_stat.pay_empty ? S_SUM : S_PRD;
                end
            end
            S_PRD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_PWR;
            end
            S_PWR: begin
                if (i_stat.out_free) begin
                    o_cmd.put = sawarq_pkg::PUT_PAY;
                    n_state   = i_stat.pay_more ? S_PRD : S_SUM;
                end
            end
            S_SUM: begin
                if (i_stat.out_free) begin
                    o_cmd.put = sawarq_pkg::PUT_SUM;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stat_code <= sawarq_pkg::ST_NONE;
            r_stat_last <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stat_code <= n_stat_code;
            r_stat_last <= n_stat_last;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

FILE: design/stop_and_wait_arq_sender_top.sv
`timescale 1ns / 1ps

// Stop-and-wait ARQ sender. Payload bytes are buffered while idle; the last
// one sends the frame (own id, destination, type, payload, 8-bit sum) and the
// block waits for an ACK, counting ticks toward a timeout, resending with a
// retry report or reporting failure when attempts run out. An input request
// is captured, then decoded with the state update. A request that sends a
// frame then outputs the header bytes, each payload byte (read through the
// one read port of the payload buffer, then output) and the checksum; a
// status report is one more output step.
// Input is stalled until the last result has been loaded into the output
// register, which then holds it against output stall. Configuration writes
// are taken in any cycle.

module stop_and_wait_arq_sender_top #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sawarq_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sawarq_pkg::t_out_item o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    sawarq_pkg::t_dp_cmd  cmd;
    sawarq_pkg::t_dp_stat stat;
    logic                 ctl_idle;
    logic                 accept;

    assign o_in_stall  = !ctl_idle;
    assign accept      = i_in_valid && ctl_idle;
    assign o_cfg_ready = 1'b1;

    sawarq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_idle   (ctl_idle)
    );

    sawarq_datapath #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_status_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_kind == sawarq_pkg::OUT_STATUS
        |-> o_out_data.frame_byte == 8'd0 && o_out_data.status != sawarq_pkg::ST_NONE)
        else $error("status report with frame byte or no status");

    a_frame_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.out_kind == sawarq_pkg::OUT_FRAME
        |-> o_out_data.status == sawarq_pkg::ST_NONE)
        else $error("frame byte carries a status");

    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("input not stalled after a request");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sawarq_pkg::*;

    localparam int PAY_DEPTH = 32;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = REG_OWN_ID;
    logic [15:0] cfg_data = '0;

    logic        in_stall;
    logic        out_valid;
    t_out_item   out_data;
    logic        cfg_ready;

    stop_and_wait_arq_sender_top #(
        .MAX_PAYLOAD(PAY_DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    // request traffic
    t_in_item  pend_q[$];
    t_out_item exp_out_q[$];
    t_out_item exp_item;
    int        n_queued = 0;
    int        n_taken = 0;
    int        err_cnt = 0;
    logic      in_took = 1'b0;
    int        src_idle_pct = 0;
    int        snk_idle_pct = 0;
    logic      hold_req = 1'b0;
    int        hold_left = 0;

    // sender state as predicted
    logic [7:0]  arq_own;
    logic [15:0] arq_tmo;
    logic [3:0]  arq_max_att;
    logic [7:0]  arq_ack;
    logic [7:0]  arq_store [PAY_DEPTH];
    logic [5:0]  arq_cnt;
    logic [7:0]  arq_dest;
    logic [7:0]  arq_type;
    logic [7:0]  arq_sum;
    logic        arq_wait;
    logic [3:0]  arq_att;
    logic [15:0] arq_ticks;
    logic [7:0]  arq_rxn;
    logic [7:0]  arq_rxsum;
    logic        arq_rxok;

    // stimulus-side view of the sender
    logic [7:0]  gen_own = OWN_ID_RST;
    int          gen_tmo = int'(TIMEOUT_RST);
    int          gen_max_att = int'(MAX_ATT_RST);
    logic [7:0]  gen_ack = ACK_TYPE_RST;
    logic [7:0]  gen_dest = '0;
    int          gen_tick = 0;
    int          gen_att = 0;
    logic [7:0]  rx_frame_q[$];

    task automatic rx_clear();
        arq_rxn = '0;
        arq_rxsum = '0;
        arq_rxok = 1'b1;
    endtask

    task automatic arq_go_idle();
        arq_wait = 1'b0;
        arq_cnt = '0;
        arq_att = '0;
        arq_ticks = '0;
        rx_clear();
    endtask

    task automatic put_out(input logic k, input logic [7:0] b, input logic [1:0] st);
        t_out_item o;
        o.out_kind = k;
        o.frame_byte = b;
        o.run_last = 1'b0;
        o.status = st;
        exp_out_q.push_back(o);
    endtask

    task automatic put_frame();
        logic [7:0] s;
        s = arq_own + arq_dest + arq_type;
        put_out(OUT_FRAME, arq_own, ST_NONE);
        put_out(OUT_FRAME, arq_dest, ST_NONE);
        put_out(OUT_FRAME, arq_type, ST_NONE);
        for (int i = 0; i < arq_cnt; i++) begin
            s = s + arq_store[i];
            put_out(OUT_FRAME, arq_store[i], ST_NONE);
        end
        arq_sum = s;
        put_out(OUT_FRAME, arq_sum, ST_NONE);
    endtask

    task automatic arq_predict(input t_in_item it);
        int        n0;
        t_out_item tmp;
        n0 = exp_out_q.size();
        if (!arq_wait) begin
            if (it.kind == KIND_PAYLOAD) begin
                if (arq_cnt < PAY_DEPTH) begin
                    arq_store[arq_cnt] = it.byte_value;
                    arq_cnt = arq_cnt + 1'b1;
                end
                if (it.last_byte) begin
                    arq_dest = it.dest_id;
                    arq_type = it.msg_type;
                    put_frame();
                    arq_wait = 1'b1;
                    arq_att = '0;
                    arq_ticks = '0;
                    rx_clear();
                end
            end
        end else if (it.kind == KIND_TICK) begin
            arq_ticks = arq_ticks + 1'b1;
            if (arq_ticks >= arq_tmo) begin
                arq_ticks = '0;
                rx_clear();
                if (arq_att < ATT_SAT) arq_att = arq_att + 1'b1;
                if (arq_att >= arq_max_att) begin
                    put_out(OUT_STATUS, 8'h00, ST_FAILED);
                    arq_go_idle();
                end else begin
                    put_out(OUT_STATUS, 8'h00, ST_RETRY);
                    put_frame();
                end
            end
        end else if (it.kind == KIND_RX) begin
            if (arq_rxn == 0 && it.byte_value != arq_dest) arq_rxok = 1'b0;
            if (arq_rxn == 1 && it.byte_value != arq_own) arq_rxok = 1'b0;
            if (arq_rxn == 2 && it.byte_value != arq_ack) arq_rxok = 1'b0;
            if (arq_rxn < RX_CNT_SAT) arq_rxn = arq_rxn + 1'b1;
            if (!it.last_byte) begin
                arq_rxsum = arq_rxsum + it.byte_value;
            end else if (arq_rxn >= ACK_MIN_LEN && arq_rxok && it.byte_value == arq_rxsum) begin
                put_out(OUT_STATUS, 8'h00, ST_ACK);
                arq_go_idle();
            end else begin
                rx_clear();
            end
        end
        if (exp_out_q.size() > n0) begin
            tmp = exp_out_q.pop_back();
            tmp.run_last = 1'b1;
            exp_out_q.push_back(tmp);
        end
    endtask

    task automatic report_field(input string name, input logic [7:0] e, input logic [7:0] a);
        err_cnt++;
        $error("%s: expected %0h, got %0h", name, e, a);
    endtask

    // monitor: samples at the rising edge
    always @(posedge clk) begin
        in_took = 1'b0;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_OWN_ID:   arq_own = cfg_data[7:0];
                    REG_TIMEOUT:  arq_tmo = cfg_data;
                    REG_MAX_ATT:  arq_max_att = cfg_data[3:0];
                    REG_ACK_TYPE: arq_ack = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (exp_out_q.size() == 0) begin
                    err_cnt++;
                    $error("unexpected result: kind %0d byte %0h last %0d status %0d",
                           out_data.out_kind, out_data.frame_byte,
                           out_data.run_last, out_data.status);
                end else begin
                    exp_item = exp_out_q.pop_front();
                    if (out_data.out_kind !== exp_item.out_kind)
                        report_field("out_kind", exp_item.out_kind, out_data.out_kind);
                    if (out_data.frame_byte !== exp_item.frame_byte)
                        report_field("frame_byte", exp_item.frame_byte, out_data.frame_byte);
                    if (out_data.run_last !== exp_item.run_last)
                        report_field("run_last", exp_item.run_last, out_data.run_last);
                    if (out_data.status !== exp_item.status)
                        report_field("status", exp_item.status, out_data.status);
                end
            end
            if (in_valid && !in_stall) begin
                in_took = 1'b1;
                n_taken++;
                arq_predict(in_data);
            end
        end
    end

    // request driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_took) begin
            if (pend_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                in_data  <= pend_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result-side stall
    always @(negedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < snk_idle_pct);
        end
    end

    task automatic push_item(input logic [1:0] k, input logic [7:0] b, input logic last,
                             input logic [7:0] dest, input logic [7:0] typ);
        t_in_item it;
        it.kind = k;
        it.byte_value = b;
        it.last_byte = last;
        it.dest_id = dest;
        it.msg_type = typ;
        pend_q.push_back(it);
        n_queued++;
    endtask

    task automatic flush_rx_frame();
        int n;
        n = rx_frame_q.size();
        for (int i = 0; i < n; i++)
            push_item(KIND_RX, rx_frame_q[i], i == n - 1, 8'($urandom_range(255)),
                      8'($urandom_range(255)));
        rx_frame_q.delete();
    endtask

    task automatic send_msg(input int n);
        logic [7:0] dest;
        for (int i = 0; i < n; i++) begin
            dest = 8'($urandom_range(255));
            push_item(KIND_PAYLOAD, 8'($urandom_range(255)), i == n - 1, dest,
                      8'($urandom_range(255)));
        end
        gen_dest = dest;
        gen_tick = 0;
        gen_att = 0;
    endtask

    task automatic good_ack(input int extra);
        logic [7:0] s;
        logic [7:0] b;
        rx_frame_q.push_back(gen_dest);
        rx_frame_q.push_back(gen_own);
        rx_frame_q.push_back(gen_ack);
        s = gen_dest + gen_own + gen_ack;
        for (int i = 0; i < extra; i++) begin
            b = 8'($urandom_range(255));
            s = s + b;
            rx_frame_q.push_back(b);
        end
        rx_frame_q.push_back(s);
        flush_rx_frame();
    endtask

    task automatic bad_ack();
        int         v;
        int         len;
        logic [7:0] hdr [3];
        logic [7:0] s;
        logic [7:0] b;
        v = $urandom_range(4);
        hdr[0] = gen_dest;
        hdr[1] = gen_own;
        hdr[2] = gen_ack;
        s = '0;
        if (v <= 2) hdr[v] = hdr[v] ^ 8'($urandom_range(255, 1));
        if (v == 4) begin
            len = $urandom_range(3, 1);
            for (int i = 0; i < len - 1; i++) begin
                rx_frame_q.push_back(hdr[i]);
                s = s + hdr[i];
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                rx_frame_q.push_back(hdr[i]);
                s = s + hdr[i];
            end
            len = $urandom_range(2);
            for (int i = 0; i < len; i++) begin
                b = 8'($urandom_range(255));
                s = s + b;
                rx_frame_q.push_back(b);
            end
            if (v == 3) s = s + 8'($urandom_range(255, 1));
        end
        rx_frame_q.push_back(s);
        flush_rx_frame();
    endtask

    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++)
            push_item(KIND_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic tick_run(output logic failed);
        push_ticks(gen_tmo - gen_tick);
        gen_tick = 0;
        gen_att++;
        failed = (gen_att >= gen_max_att);
    endtask

    task automatic partial_ticks();
        int room;
        int k;
        room = gen_tmo - gen_tick - 1;
        if (room > 0) begin
            k = $urandom_range((room < 4) ? room : 4, 1);
            push_ticks(k);
            gen_tick += k;
        end
    endtask

    task automatic wait_noise();
        int k;
        k = $urandom_range(2, 1);
        for (int i = 0; i < k; i++)
            push_item($urandom_range(1) ? KIND_NONE : KIND_PAYLOAD, 8'($urandom_range(255)),
                      1'($urandom_range(1)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
    endtask

    task automatic idle_noise();
        int         k;
        int         r;
        logic [1:0] kd;
        k = $urandom_range(3, 1);
        for (int i = 0; i < k; i++) begin
            r = $urandom_range(2);
            kd = (r == 0) ? KIND_TICK : (r == 1) ? KIND_RX : KIND_NONE;
            push_item(kd, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
        end
    endtask

    task automatic run_message(input int n);
        logic done;
        logic to_fail;
        int   r;
        int   guard;
        send_msg(n);
        done = 1'b0;
        guard = 0;
        to_fail = (gen_tmo <= 16) && ($urandom_range(99) < 30);
        while (!done) begin
            r = $urandom_range(99);
            guard++;
            if (to_fail) begin
                if (r < 70) tick_run(done);
                else if (r < 85) bad_ack();
                else wait_noise();
            end else begin
                if (guard > 30) r = 0;
                if (r < 40) begin
                    good_ack($urandom_range(4));
                    done = 1'b1;
                end else if (r < 60 && gen_tmo <= 16) begin
                    tick_run(done);
                end else if (r < 75) begin
                    bad_ack();
                end else if (r < 88) begin
                    partial_ticks();
                end else begin
                    wait_noise();
                end
            end
        end
    endtask

    task automatic run_random(input int budget);
        int start;
        int r;
        start = n_queued;
        while (n_queued - start < budget) begin
            if ($urandom_range(99) < 20) idle_noise();
            r = $urandom_range(99);
            if (r < 80) run_message($urandom_range(6, 1));
            else if (r < 95) run_message($urandom_range(PAY_DEPTH, 7));
            else run_message($urandom_range(PAY_DEPTH + 8, PAY_DEPTH + 1));
        end
    endtask

    task automatic wait_idle();
        do @(negedge clk); while (n_taken != n_queued || exp_out_q.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic cfg_put(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic write_cfg(input logic [7:0] own, input logic [15:0] tmo,
                             input logic [3:0] att, input logic [7:0] ack);
        cfg_put(REG_OWN_ID, {8'($urandom_range(255)), own});
        cfg_put(REG_TIMEOUT, tmo);
        cfg_put(REG_MAX_ATT, {12'($urandom_range(4095)), att});
        cfg_put(REG_ACK_TYPE, {8'($urandom_range(255)), ack});
        cfg_valid <= 1'b0;
        gen_own = own;
        gen_tmo = int'(tmo);
        gen_max_att = int'(att);
        gen_ack = ack;
    endtask

    initial begin
        arq_own = OWN_ID_RST;
        arq_tmo = TIMEOUT_RST;
        arq_max_att = MAX_ATT_RST;
        arq_ack = ACK_TYPE_RST;
        for (int i = 0; i < PAY_DEPTH; i++) arq_store[i] = '0;
        arq_dest = '0;
        arq_type = '0;
        arq_sum = '0;
        arq_go_idle();

        src_idle_pct = 12;
        snk_idle_pct = 72;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // idle sender ignores ticks, received bytes and unused kinds
        push_item(KIND_TICK, 8'h00, 1'b0, 8'h00, 8'h00);
        push_item(KIND_RX, 8'hFF, 1'b1, 8'hFF, 8'hFF);
        push_item(KIND_NONE, 8'hFF, 1'b1, 8'hFF, 8'hFF);
        push_item(KIND_PAYLOAD, 8'h00, 1'b0, 8'h00, 8'h00);
        push_item(KIND_PAYLOAD, 8'hFF, 1'b1, 8'hFF, 8'h00);
        gen_dest = 8'hFF;
        gen_tick = 0;
        gen_att = 0;
        // payload and unused kind while waiting are dropped
        push_item(KIND_PAYLOAD, 8'hAA, 1'b1, 8'h55, 8'h55);
        push_item(KIND_NONE, 8'h00, 1'b0, 8'h00, 8'h00);
        push_ticks(2);
        gen_tick = 2;
        // wrong ack type
        rx_frame_q.push_back(8'hFF);
        rx_frame_q.push_back(gen_own);
        rx_frame_q.push_back(8'hFF);
        rx_frame_q.push_back(8'hFF + gen_own + 8'hFF);
        flush_rx_frame();
        // too short
        rx_frame_q.push_back(8'hFF);
        rx_frame_q.push_back(gen_own);
        rx_frame_q.push_back(8'hFF + gen_own);
        flush_rx_frame();
        good_ack(0);
        push_item(KIND_PAYLOAD, 8'h80, 1'b1, 8'h00, 8'hFF);
        gen_dest = 8'h00;
        good_ack(1);

        // ack longer than the receive counter range
        send_msg(2);
        good_ack(253);
        run_random(8);
        wait_idle();

        write_cfg(8'h00, 16'd1, 4'd1, 8'hFF);
        run_random(8);
        wait_idle();

        src_idle_pct = 72;
        snk_idle_pct = 12;
        write_cfg(8'hFF, 16'hFFFF, 4'd15, 8'h00);
        run_random(8);
        wait_idle();

        write_cfg(8'($urandom_range(255)), 16'd3, 4'd15, 8'($urandom_range(255)));
        run_random(8);
        wait_idle();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_cfg(8'($urandom_range(255)), 16'($urandom_range(5, 1)),
                  4'($urandom_range(5, 2)), 8'($urandom_range(255)));
        run_random(8);
        hold_req = 1'b1;
        wait_idle();

        write_cfg(8'($urandom_range(255)), 16'd2, 4'd2, 8'($urandom_range(255)));
        run_random(8);
        wait_idle();

        repeat (20) @(negedge clk);
        if (err_cnt == 0 && exp_out_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: stop_and_wait_arq_sender_top.f
design/sawarq_pkg.sv
design/sawarq_datapath.sv
design/sawarq_ctrl.sv
design/stop_and_wait_arq_sender_top.sv
tb/tb_top.sv
